// File: rtl/segment_descriptor_table_unit_defines.svh
// assertion macros shared by the segment descriptor table rtl
`ifndef SEGMENT_DESCRIPTOR_TABLE_UNIT_DEFINES_SVH
`define SEGMENT_DESCRIPTOR_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sdt assertion failed");

// next-cycle implication, checked outside reset
`define SDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sdt assertion failed");

`endif

// File: rtl/sdt_pkg.sv
// types, codes and descriptor packing helpers for the segment descriptor table
`default_nettype none
package sdt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_FIND     = 2'd1,
    OP_GET_BASE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_RD,
    S_GET_CHK,
    S_SCAN,
    S_FINISH
  } state_e;

  localparam int unsigned DESC_W = 64;
  localparam logic [3:0]  GRAN_FLAG = 4'h8;
  localparam logic [31:0] LIMIT_SCALE_THRESHOLD = 32'h0001_0000;
  localparam int unsigned LIMIT_SCALE_SHIFT = 12;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch request transaction
    logic wr_en;      // write packed descriptor
    logic ptr_load;   // load read pointer with start index
    logic rd_en;      // issue table read at pointer
    logic res_range;  // result: index beyond table
    logic res_nofree; // result: no free entry
    logic res_hit;    // result: free entry at checked index
    logic res_base;   // result: base from checked entry
    logic rsp_load;   // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic idx_ok;
    logic sel_ok;
    logic chk_vld;
    logic chk_free;
    logic chk_last;
    logic rsp_free;
  } stat_t;

  function automatic logic [DESC_W-1:0] pack_descriptor(
    input logic [31:0] base,
    input logic [31:0] limit,
    input logic [7:0]  access,
    input logic [3:0]  flags
  );
    logic [31:0] lim;
    logic [3:0]  flg;
    lim = limit;
    flg = flags;
    if (limit > LIMIT_SCALE_THRESHOLD) begin
      lim = limit >> LIMIT_SCALE_SHIFT;
      flg = flags | GRAN_FLAG;
    end
    return {base[31:24], flg, lim[19:16], access, base[23:0], lim[15:0]};
  endfunction

  function automatic logic [31:0] unpack_base(input logic [DESC_W-1:0] d);
    return {d[63:56], d[39:16]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/sdt_req_if.sv
// request channel: valid/ready handshake with operation fields
`default_nettype none
interface sdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  entry_index;
  logic [15:0] selector;
  logic [31:0] seg_base;
  logic [31:0] seg_limit;
  logic [7:0]  access_byte;
  logic [3:0]  flag_nibble;

  modport source (
    output valid, op, entry_index, selector, seg_base, seg_limit, access_byte, flag_nibble,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, selector, seg_base, seg_limit, access_byte, flag_nibble,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/sdt_rsp_if.sv
// response channel: valid/ready handshake with result fields
`default_nettype none
interface sdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  found_index;
  logic [31:0] segment_base;

  modport source (
    output valid, status, found_index, segment_base,
    input  ready
  );
  modport sink (
    input  valid, status, found_index, segment_base,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/sdt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module sdt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/sdt_datapath.sv
// request latch, descriptor table, scan pointer and result registers
`default_nettype none
module sdt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 32,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sdt_pkg::cmd_t  cmd_i,
  output sdt_pkg::stat_t      stat_o,
  input  wire logic [1:0]     op_i,
  input  wire logic [7:0]     entry_index_i,
  input  wire logic [15:0]    selector_i,
  input  wire logic [31:0]    seg_base_i,
  input  wire logic [31:0]    seg_limit_i,
  input  wire logic [7:0]     access_byte_i,
  input  wire logic [3:0]     flag_nibble_i,
  input  wire logic           rsp_ready_i,
  output logic                rsp_valid_o,
  output logic [1:0]          status_o,
  output logic [7:0]          found_index_o,
  output logic [31:0]         segment_base_o
);
  import sdt_pkg::*;

  // latched request
  op_e         op_q;
  logic [7:0]  idx_q;
  logic [12:0] tidx_q;
  logic [31:0] base_q;
  logic [31:0] limit_q;
  logic [7:0]  access_q;
  logic [3:0]  flags_q;

  // scan and check
  logic [AW-1:0] rd_ptr_q;
  logic [AW-1:0] chk_ptr_q;
  logic          chk_vld_q;
  logic          chk_last_q;
  logic          ent_valid_q;
  logic          rd_last;
  logic [AW-1:0] start_addr;
  logic [DESC_W-1:0] rd_data;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // pending result and output register
  status_e     res_status_q;
  logic [7:0]  res_found_q;
  logic [31:0] res_base_q;
  logic        rsp_valid_q;
  logic [1:0]  rsp_status_q;
  logic [7:0]  rsp_found_q;
  logic [31:0] rsp_base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(op_i);
      idx_q    <= entry_index_i;
      tidx_q   <= selector_i[15:3];
      base_q   <= seg_base_i;
      limit_q  <= seg_limit_i;
      access_q <= access_byte_i;
      flags_q  <= flag_nibble_i;
    end
  end

  assign rd_last    = (rd_ptr_q == AW'(TABLE_ENTRIES - 1));
  assign start_addr = (op_q == OP_GET_BASE) ? tidx_q[AW-1:0] : idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr_load) begin
      rd_ptr_q <= start_addr;
    end else if (cmd_i.rd_en && !rd_last) begin
      rd_ptr_q <= rd_ptr_q + AW'(1);
    end
    if (cmd_i.rd_en) begin
      chk_ptr_q   <= rd_ptr_q;
      chk_last_q  <= rd_last;
      ent_valid_q <= valid_q[rd_ptr_q];
    end
  end

  // per-entry written flags; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.rd_en;
      if (cmd_i.wr_en) begin
        valid_q[idx_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  sdt_ram #(
    .WIDTH (DESC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (pack_descriptor(base_q, limit_q, access_q, flags_q)),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q <= ST_OK;
      res_found_q  <= '0;
      res_base_q   <= '0;
    end else begin
      if (cmd_i.res_range) begin
        res_status_q <= ST_RANGE;
      end
      if (cmd_i.res_nofree) begin
        res_status_q <= ST_NO_FREE;
        res_found_q  <= '0;
      end
      if (cmd_i.res_hit) begin
        res_found_q <= 8'(chk_ptr_q);
      end
      if (cmd_i.res_base) begin
        res_base_q <= ent_valid_q ? unpack_base(rd_data) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_found_q  <= res_found_q;
      rsp_base_q   <= res_base_q;
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.idx_ok   = ({1'b0, idx_q} < 9'(TABLE_ENTRIES));
  assign stat_o.sel_ok   = (tidx_q < 13'(TABLE_ENTRIES));
  assign stat_o.chk_vld  = chk_vld_q;
  assign stat_o.chk_free = !ent_valid_q || (rd_data == '0);
  assign stat_o.chk_last = chk_last_q;
  assign stat_o.rsp_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o    = rsp_valid_q;
  assign status_o       = rsp_status_q;
  assign found_index_o  = rsp_found_q;
  assign segment_base_o = rsp_base_q;

endmodule
`default_nettype wire

// File: rtl/sdt_ctrl.sv
// operation sequencer: decode, table read, free scan and result hand-off
`default_nettype none
module sdt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire sdt_pkg::stat_t stat_i,
  output sdt_pkg::cmd_t       cmd_o
);
  import sdt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.idx_ok) begin
              cmd_o.wr_en = 1'b1;
            end else begin
              cmd_o.res_range = 1'b1;
            end
          end
          OP_FIND: begin
            if (stat_i.idx_ok) begin
              cmd_o.ptr_load = 1'b1;
              state_d        = S_SCAN;
            end else begin
              cmd_o.res_nofree = 1'b1;
            end
          end
          OP_GET_BASE: begin
            if (stat_i.sel_ok) begin
              cmd_o.ptr_load = 1'b1;
              state_d        = S_GET_RD;
            end else begin
              cmd_o.res_range = 1'b1;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_GET_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_GET_CHK;
      end
      S_GET_CHK: begin
        cmd_o.res_base = 1'b1;
        state_d        = S_FINISH;
      end
      S_SCAN: begin
        // reads stream one per cycle; each check uses the registered read data
        cmd_o.rd_en = 1'b1;
        if (stat_i.chk_vld && stat_i.chk_free) begin
          cmd_o.res_hit = 1'b1;
          state_d       = S_FINISH;
        end else if (stat_i.chk_vld && stat_i.chk_last) begin
          cmd_o.res_nofree = 1'b1;
          state_d          = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.rsp_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/segment_descriptor_table_unit.sv
// top level of the segment descriptor table: sequencer plus table datapath
//
// channel  dir  modport  contents
// req_i    in   sink     op, entry_index, selector, seg_base, seg_limit, access_byte, flag_nibble
// rsp_o    out  source   status, found_index, segment_base
//
// one request transaction in flight at a time; insert and out-of-range or
// unused ops pass from decode straight to finish and the output register,
// get base adds a table read and a check, and find free scans from the
// entry index upward, one table read per cycle through the single ram read port
// reset clears every entry at once through per-entry written flags, no sweep
// a stalled response holds the result in the output register while the
// next request transaction is taken and worked on up to its hand-off
`default_nettype none
`include "segment_descriptor_table_unit_defines.svh"
module segment_descriptor_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdt_req_if.sink    req_i,
  sdt_rsp_if.source  rsp_o
);
  import sdt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  sdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table, scan pointer and result registers
  sdt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (req_i.op),
    .entry_index_i  (req_i.entry_index),
    .selector_i     (req_i.selector),
    .seg_base_i     (req_i.seg_base),
    .seg_limit_i    (req_i.seg_limit),
    .access_byte_i  (req_i.access_byte),
    .flag_nibble_i  (req_i.flag_nibble),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .found_index_o  (rsp_o.found_index),
    .segment_base_o (rsp_o.segment_base)
  );

  // one transaction at a time: after a request is taken, ready drops
  `SDT_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)

  // a pending result is never overwritten before it is taken
  `SDT_ASSERT_NOW(a_no_rsp_overwrite, clk_i, rst_ni, cmd.rsp_load,
                  !rsp_o.valid || rsp_o.ready)

  // a failed find always reports index zero
  `SDT_ASSERT_NOW(a_nofree_zero_idx, clk_i, rst_ni,
                  rsp_o.valid && (rsp_o.status == ST_NO_FREE), rsp_o.found_index == 8'd0)

  // table writes and reads never share a cycle
  `SDT_ASSERT_NOW(a_wr_rd_excl, clk_i, rst_ni, cmd.wr_en, !cmd.rd_en)

endmodule
`default_nettype wire
